FILE: hw/rtl/ckb_pkg.sv
`default_nettype none
package ckb_pkg;

    localparam int PIXEL_BITS     = 16;
    localparam int COORD_BITS     = 12;
    localparam int ALPHA_BITS     = 8;
    localparam int SIZE_BITS      = COORD_BITS + 1;
    localparam int ANCHOR_BITS    = COORD_BITS + 2;
    localparam int POS_BITS       = ANCHOR_BITS + 2;
    localparam int MODE_BITS      = 2;
    localparam int CFG_INDEX_BITS = 4;
    localparam int CFG_DATA_BITS  = ANCHOR_BITS;

    localparam logic [CFG_INDEX_BITS-1:0] REG_SCREEN_WIDTH   = CFG_INDEX_BITS'(0);
    localparam logic [CFG_INDEX_BITS-1:0] REG_SCREEN_HEIGHT  = CFG_INDEX_BITS'(1);
    localparam logic [CFG_INDEX_BITS-1:0] REG_ANCHOR_X       = CFG_INDEX_BITS'(2);
    localparam logic [CFG_INDEX_BITS-1:0] REG_ANCHOR_Y       = CFG_INDEX_BITS'(3);
    localparam logic [CFG_INDEX_BITS-1:0] REG_GRAPHIC_WIDTH  = CFG_INDEX_BITS'(4);
    localparam logic [CFG_INDEX_BITS-1:0] REG_GRAPHIC_HEIGHT = CFG_INDEX_BITS'(5);
    localparam logic [CFG_INDEX_BITS-1:0] REG_BLIT_MODE      = CFG_INDEX_BITS'(6);
    localparam logic [CFG_INDEX_BITS-1:0] REG_KEY_VALUE      = CFG_INDEX_BITS'(7);

    localparam logic [SIZE_BITS-1:0] SCREEN_WIDTH_RESET  = SIZE_BITS'(640);
    localparam logic [SIZE_BITS-1:0] SCREEN_HEIGHT_RESET = SIZE_BITS'(480);

    localparam int MODE_CENTER_BIT = 0;
    localparam int MODE_KEY_BIT    = 1;

    localparam logic [COORD_BITS-1:0] COUNT_MAX = {COORD_BITS{1'b1}};

    typedef struct packed {
        logic [SIZE_BITS-1:0]   screen_width;
        logic [SIZE_BITS-1:0]   screen_height;
        logic [ANCHOR_BITS-1:0] anchor_x;
        logic [ANCHOR_BITS-1:0] anchor_y;
        logic [SIZE_BITS-1:0]   graphic_width;
        logic [SIZE_BITS-1:0]   graphic_height;
        logic [MODE_BITS-1:0]   blit_mode;
        logic [ALPHA_BITS-1:0]  key_value;
    } cfg_t;

    typedef struct packed {
        logic [PIXEL_BITS-1:0] pixel;
        logic [ALPHA_BITS-1:0] alpha;
        logic [COORD_BITS-1:0] column;
        logic [COORD_BITS-1:0] row;
        logic                  last;
    } src_t;

    typedef struct packed {
        logic                  write_enable;
        logic [COORD_BITS-1:0] dest_x;
        logic [COORD_BITS-1:0] dest_y;
        logic [PIXEL_BITS-1:0] pixel;
        logic                  last;
    } res_t;

endpackage
`default_nettype wire

FILE: hw/rtl/ckb_cfg.sv
`default_nettype none
module ckb_cfg (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              wr_en,
    input  wire logic [ckb_pkg::CFG_INDEX_BITS-1:0] wr_index,
    input  wire logic [ckb_pkg::CFG_DATA_BITS-1:0]  wr_data,
    output ckb_pkg::cfg_t                          cfg
);
    import ckb_pkg::*;

    cfg_t cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.screen_width   <= SCREEN_WIDTH_RESET;
            cfg_reg.screen_height  <= SCREEN_HEIGHT_RESET;
            cfg_reg.anchor_x       <= '0;
            cfg_reg.anchor_y       <= '0;
            cfg_reg.graphic_width  <= '0;
            cfg_reg.graphic_height <= '0;
            cfg_reg.blit_mode      <= '0;
            cfg_reg.key_value      <= '0;
        end
        else if (wr_en)
        begin
            case (wr_index)
                REG_SCREEN_WIDTH:   cfg_reg.screen_width   <= wr_data[SIZE_BITS-1:0];
                REG_SCREEN_HEIGHT:  cfg_reg.screen_height  <= wr_data[SIZE_BITS-1:0];
                REG_ANCHOR_X:       cfg_reg.anchor_x       <= wr_data[ANCHOR_BITS-1:0];
                REG_ANCHOR_Y:       cfg_reg.anchor_y       <= wr_data[ANCHOR_BITS-1:0];
                REG_GRAPHIC_WIDTH:  cfg_reg.graphic_width  <= wr_data[SIZE_BITS-1:0];
                REG_GRAPHIC_HEIGHT: cfg_reg.graphic_height <= wr_data[SIZE_BITS-1:0];
                REG_BLIT_MODE:      cfg_reg.blit_mode      <= wr_data[MODE_BITS-1:0];
                REG_KEY_VALUE:      cfg_reg.key_value      <= wr_data[ALPHA_BITS-1:0];
                default:            cfg_reg                <= cfg_reg;
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule
`default_nettype wire

FILE: hw/rtl/ckb_pos.sv
`default_nettype none
module ckb_pos (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          advance,
    input  wire ckb_pkg::cfg_t                 cfg,
    output logic [ckb_pkg::COORD_BITS-1:0]     column,
    output logic [ckb_pkg::COORD_BITS-1:0]     row,
    output logic                               last
);
    import ckb_pkg::*;

    logic [COORD_BITS-1:0] column_reg;
    logic [COORD_BITS-1:0] row_reg;
    logic [COORD_BITS-1:0] column_next;
    logic [COORD_BITS-1:0] row_next;
    logic                  row_end;

    assign row_end = (({1'b0, column_reg} + SIZE_BITS'(1)) >= cfg.graphic_width)
                     || (column_reg == COUNT_MAX);
    assign last    = row_end && (((({1'b0, row_reg} + SIZE_BITS'(1)) >= cfg.graphic_height))
                     || (row_reg == COUNT_MAX));

    always_comb
    begin
        column_next = column_reg;
        row_next    = row_reg;
        if (last)
        begin
            column_next = '0;
            row_next    = '0;
        end
        else if (row_end)
        begin
            column_next = '0;
            row_next    = row_reg + COORD_BITS'(1);
        end
        else
        begin
            column_next = column_reg + COORD_BITS'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            column_reg <= '0;
            row_reg    <= '0;
        end
        else if (advance)
        begin
            column_reg <= column_next;
            row_reg    <= row_next;
        end
    end

    assign column = column_reg;
    assign row    = row_reg;

endmodule
`default_nettype wire

FILE: hw/rtl/ckb_clip.sv
`default_nettype none
module ckb_clip (
    input  wire ckb_pkg::src_t src,
    input  wire ckb_pkg::cfg_t cfg,
    output ckb_pkg::res_t      res
);
    import ckb_pkg::*;

    logic [POS_BITS-1:0] anchor_x_ext;
    logic [POS_BITS-1:0] anchor_y_ext;
    logic [POS_BITS-1:0] half_x;
    logic [POS_BITS-1:0] half_y;
    logic [POS_BITS-1:0] dx;
    logic [POS_BITS-1:0] dy;
    logic                visible;
    logic                keyed_out;

    function automatic logic on_axis(input logic [POS_BITS-1:0] pos,
                                     input logic [SIZE_BITS-1:0] limit);
        logic below;
        below = pos < {{(POS_BITS-SIZE_BITS){1'b0}}, limit};
        return !pos[POS_BITS-1] && below && (pos[POS_BITS-1:COORD_BITS] == '0);
    endfunction

    assign anchor_x_ext = {{(POS_BITS-ANCHOR_BITS){cfg.anchor_x[ANCHOR_BITS-1]}}, cfg.anchor_x};
    assign anchor_y_ext = {{(POS_BITS-ANCHOR_BITS){cfg.anchor_y[ANCHOR_BITS-1]}}, cfg.anchor_y};

    always_comb
    begin
        half_x = '0;
        half_y = '0;
        if (cfg.blit_mode[MODE_CENTER_BIT])
        begin
            half_x = {{(POS_BITS-SIZE_BITS+1){1'b0}}, cfg.graphic_width[SIZE_BITS-1:1]};
            half_y = {{(POS_BITS-SIZE_BITS+1){1'b0}}, cfg.graphic_height[SIZE_BITS-1:1]};
        end
    end

    assign dx = anchor_x_ext + {{(POS_BITS-COORD_BITS){1'b0}}, src.column} - half_x;
    assign dy = anchor_y_ext + {{(POS_BITS-COORD_BITS){1'b0}}, src.row} - half_y;

    assign visible   = on_axis(dx, cfg.screen_width) && on_axis(dy, cfg.screen_height);
    assign keyed_out = cfg.blit_mode[MODE_KEY_BIT] && (src.alpha == cfg.key_value);

    always_comb
    begin
        res.write_enable = visible && !keyed_out;
        res.dest_x       = res.write_enable ? dx[COORD_BITS-1:0] : '0;
        res.dest_y       = res.write_enable ? dy[COORD_BITS-1:0] : '0;
        res.pixel        = src.pixel;
        res.last         = src.last;
    end

endmodule
`default_nettype wire

FILE: hw/rtl/clipped_keyed_blit_core.sv
// Clipped, optionally centered and alpha-keyed 2D blit of a raster-ordered graphic.
// Input channel: in_valid / in_stall with pixel_value and alpha_byte, one source
// pixel per transaction in raster order; a row/column counter tracks its place.
// Output channel: out_valid / out_stall with write_enable, dest_x, dest_y,
// pixel_out and last_pixel, one transaction per input transaction, in order.
// Configuration: cfg_valid / cfg_ready with cfg_index and cfg_data; cfg_ready is
// always high. Write registers only while no transaction is in flight.
// Path: an accepted pixel passes the input register, then the result register,
// before it is offered on the output. Throughput: one pixel per cycle while
// the receiver does not stall, set by the two-stage register pipeline.
// When the receiver stalls, the result register holds, the input register
// fills, and in_stall rises; it falls in the cycle the output is taken.
// Reset clears both counters, the pipeline valids and loads register defaults
// (screen 640 x 480, everything else zero).
`default_nettype none
module clipped_keyed_blit_core (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              in_valid,
    output logic                                   in_stall,
    input  wire logic [ckb_pkg::PIXEL_BITS-1:0]     pixel_value,
    input  wire logic [ckb_pkg::ALPHA_BITS-1:0]     alpha_byte,
    output logic                                   out_valid,
    input  wire logic                              out_stall,
    output logic                                   write_enable,
    output logic [ckb_pkg::COORD_BITS-1:0]         dest_x,
    output logic [ckb_pkg::COORD_BITS-1:0]         dest_y,
    output logic [ckb_pkg::PIXEL_BITS-1:0]         pixel_out,
    output logic                                   last_pixel,
    input  wire logic                              cfg_valid,
    output logic                                   cfg_ready,
    input  wire logic [ckb_pkg::CFG_INDEX_BITS-1:0] cfg_index,
    input  wire logic [ckb_pkg::CFG_DATA_BITS-1:0]  cfg_data
);
    import ckb_pkg::*;

    cfg_t                  cfg;
    logic                  in_accept;
    logic [COORD_BITS-1:0] column;
    logic [COORD_BITS-1:0] row;
    logic                  last;
    src_t                  src_reg;
    src_t                  src_next;
    logic                  src_valid_reg;
    res_t                  res;
    res_t                  res_reg;
    logic                  out_valid_reg;
    logic                  out_free;
    logic                  src_move;

    assign cfg_ready = 1'b1;

    ckb_cfg u_cfg (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (cfg_valid && cfg_ready),
        .wr_index (cfg_index),
        .wr_data  (cfg_data),
        .cfg      (cfg)
    );

    ckb_pos u_pos (
        .clk     (clk),
        .rst_n   (rst_n),
        .advance (in_accept),
        .cfg     (cfg),
        .column  (column),
        .row     (row),
        .last    (last)
    );

    ckb_clip u_clip (
        .src (src_reg),
        .cfg (cfg),
        .res (res)
    );

    assign out_free  = !out_valid_reg || !out_stall;
    assign src_move  = src_valid_reg && out_free;
    assign in_stall  = src_valid_reg && !out_free;
    assign in_accept = in_valid && !in_stall;

    always_comb
    begin
        src_next.pixel  = pixel_value;
        src_next.alpha  = alpha_byte;
        src_next.column = column;
        src_next.row    = row;
        src_next.last   = last;
    end

    // advance the input stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            src_valid_reg <= 1'b0;
        end
        else if (in_accept)
        begin
            src_valid_reg <= 1'b1;
        end
        else if (src_move)
        begin
            src_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            src_reg <= src_next;
        end
    end

    // advance the result stage; hold while stalled
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_free)
        begin
            out_valid_reg <= src_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (src_move)
        begin
            res_reg <= res;
        end
    end

    assign out_valid    = out_valid_reg;
    assign write_enable = res_reg.write_enable;
    assign dest_x       = res_reg.dest_x;
    assign dest_y       = res_reg.dest_y;
    assign pixel_out    = res_reg.pixel;
    assign last_pixel   = res_reg.last;

endmodule
`default_nettype wire
